### sv/gbe_pkg.sv
// Shared package for the UTF-8 gap buffer editor.
// Holds the operation codes and the UTF-8 rune decoder used by the rune checker.
// No dependencies.
package gbe_pkg;

	typedef enum logic [3:0] {
		OP_INSERT        = 4'd0,
		OP_BYTE_BACK     = 4'd1,
		OP_BYTE_FWD      = 4'd2,
		OP_RUNE_BACK     = 4'd3,
		OP_RUNE_FWD      = 4'd4,
		OP_DEL_BYTE_BACK = 4'd5,
		OP_DEL_BYTE_FWD  = 4'd6,
		OP_DEL_RUNE_BACK = 4'd7,
		OP_DEL_RUNE_FWD  = 4'd8
	} op_t;

	localparam int unsigned WinBytes = 4;

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	// Length of a valid rune led by b0, or zero. Overlong forms, surrogates and
	// values above the Unicode range are rejected through the lead byte and the second byte.
	function automatic logic [2:0] rune_len(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3);
		logic [2:0] len;
		len = 3'd0;
		if (b0 < 8'h80) begin
			len = 3'd1;
		end else if (b0 >= 8'hC2 && b0 <= 8'hDF) begin
			if (is_cont(b1)) len = 3'd2;
		end else if (b0 >= 8'hE0 && b0 <= 8'hEF) begin
			if (is_cont(b1) && is_cont(b2) && (b0 != 8'hE0 || b1 >= 8'hA0)
				&& (b0 != 8'hED || b1 <= 8'h9F)) len = 3'd3;
		end else if (b0 >= 8'hF0 && b0 <= 8'hF4) begin
			if (is_cont(b1) && is_cont(b2) && is_cont(b3) && (b0 != 8'hF0 || b1 >= 8'h90)
				&& (b0 != 8'hF4 || b1 <= 8'h8F)) len = 3'd4;
		end
		return len;
	endfunction

endpackage

### sv/gbe_store.sv
// Text store of the gap buffer: one write port and one registered read port.
// Depends on nothing.
module gbe_store #(
	parameter int CAPACITY = 4096,
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

### sv/gbe_rune_check.sv
// Finds the length of the rune next to the gap from a window of fetched bytes.
// Depends on gbe_pkg.
module gbe_rune_check (
	input  logic [7:0] win [gbe_pkg::WinBytes],
	input  logic [2:0] nread,
	input  logic       back,
	output logic [2:0] len
);
	logic [2:0] fwd_len;
	logic [2:0] back_len;

	always_comb begin
		// Backward: the window runs away from the gap, so a rune of length L
		// starts at win[L-1]. The shortest fitting length wins.
		back_len = 3'd0;
		if (nread >= 3'd4 && gbe_pkg::rune_len(win[3], win[2], win[1], win[0]) == 3'd4)
			back_len = 3'd4;
		if (nread >= 3'd3 && gbe_pkg::rune_len(win[2], win[1], win[0], 8'h00) == 3'd3)
			back_len = 3'd3;
		if (nread >= 3'd2 && gbe_pkg::rune_len(win[1], win[0], 8'h00, 8'h00) == 3'd2)
			back_len = 3'd2;
		if (nread >= 3'd1 && gbe_pkg::rune_len(win[0], 8'h00, 8'h00, 8'h00) == 3'd1)
			back_len = 3'd1;
		fwd_len = gbe_pkg::rune_len(win[0], win[1], win[2], win[3]);
		if (fwd_len > nread) fwd_len = 3'd0;
		len = back ? back_len : fwd_len;
	end
endmodule

### sv/utf8_gap_buffer_editor_core.sv
// Top level of the UTF-8 gap buffer editor: command sequencer, pointers and result register.
// Depends on gbe_pkg, gbe_store and gbe_rune_check.
//
//   Channel | Signals                                         | Direction
//   input   | in_valid, in_stall, operation, data_byte, count | into the block
//   output  | out_valid, out_stall, done_count, cursor_pos,   | out of the block
//           | free_bytes, full_res                            |
//
// One item is worked on at a time. An insert, a byte delete or an unused code goes from
// acceptance through the execute and done states to the result. Moves and rune deletes go
// unit by unit: a check, one store read per byte looked at (one for a byte step, up to
// four for a rune step), a fetch wait, a decode and, for moves, one write per byte copied.
// The text store takes one read and one write per cycle.
// Reset clears pointers and control state; the text store itself is not cleared.
// in_stall is high while an item is in progress; a result held by out_stall does
// not block acceptance of the next item, only the completion of that next item.
module utf8_gap_buffer_editor_core #(
	parameter int CAPACITY = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  operation,
	input  logic [7:0]  data_byte,
	input  logic [12:0] count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] done_count,
	output logic [11:0] cursor_pos,
	output logic [12:0] free_bytes,
	output logic        full_res
);
	localparam int AW = $clog2(CAPACITY);
	// Wide enough for the gap size and for the count field.
	localparam int CW = (AW + 1 > 13) ? AW + 1 : 13;
	localparam logic [AW-1:0] LastIdx = AW'(CAPACITY - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_CHK, S_RD, S_RWAIT, S_EVAL, S_WR, S_DONE
	} state_t;

	localparam state_t S_INS_W = S_EXEC;

	state_t        state_q;
	logic [3:0]    op_q;
	logic [7:0]    byte_q;
	logic [12:0]   n_q;
	logic [12:0]   done_q;
	logic          full_q;
	logic          back_q;
	logic          rune_q;
	logic          del_q;
	logic [AW-1:0] gs_q;
	logic [AW-1:0] ge_q;
	logic [AW:0]   gb_q;
	logic [2:0]    nread_q;
	logic [1:0]    rk_q;
	logic [1:0]    wk_q;
	logic [2:0]    len_q;
	logic [7:0]    win_q [gbe_pkg::WinBytes];

	// Read pipeline: the store returns data in the cycle after the address.
	logic          pend_s1;
	logic [1:0]    idx_s1;

	logic [AW-1:0] avail;
	logic [CW-1:0] gs_w;
	logic [CW-1:0] gb_w;
	logic [CW-1:0] avail_w;
	logic [CW-1:0] n_w;
	logic [CW-1:0] take;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic          we;
	logic [7:0]    rdata;
	logic [2:0]    chk_len;
	logic [2:0]    unit_len;
	logic [2:0]    lim;

	// Bytes of text after the gap.
	assign avail   = LastIdx - ge_q;
	assign gs_w    = CW'(gs_q);
	assign gb_w    = CW'(gb_q);
	assign avail_w = CW'(avail);
	assign n_w     = CW'(n_q);

	always_comb begin
		if (back_q) take = (n_w >= gs_w) ? gs_w : n_w;
		else        take = (n_w >= avail_w) ? avail_w : n_w;
		// How many bytes a rune step may look at on its side of the gap.
		if (back_q) lim = (gs_q >= AW'(4)) ? 3'd4 : gs_q[2:0];
		else        lim = (avail >= AW'(4)) ? 3'd4 : avail[2:0];
		unit_len = rune_q ? chk_len : 3'd1;
		raddr = back_q ? (gs_q - AW'(1) - AW'(rk_q)) : (ge_q + AW'(1) + AW'(rk_q));
		// A backward move fills the gap's tail, a forward move its head.
		if (state_q == S_INS_W) begin
			waddr = gs_q;
			wdata = byte_q;
		end else begin
			waddr = back_q ? (ge_q - AW'(wk_q)) : (gs_q + AW'(wk_q));
			wdata = win_q[wk_q];
		end
	end

	assign we = (state_q == S_EXEC && op_q == gbe_pkg::OP_INSERT && gb_q >= (AW+1)'(2))
		|| state_q == S_WR;

	gbe_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	gbe_rune_check u_check (
		.win(win_q), .nread(nread_q), .back(back_q), .len(chk_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			idx_s1  <= 2'd0;
		end else begin
			pend_s1 <= (state_q == S_RD);
			idx_s1  <= rk_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) win_q[idx_s1] <= rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			gs_q      <= '0;
			ge_q      <= LastIdx;
			gb_q      <= (AW+1)'(CAPACITY);
			op_q      <= '0;
			byte_q    <= '0;
			n_q       <= '0;
			done_q    <= '0;
			full_q    <= 1'b0;
			back_q    <= 1'b0;
			rune_q    <= 1'b0;
			del_q     <= 1'b0;
			nread_q   <= '0;
			rk_q      <= '0;
			wk_q      <= '0;
			len_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= operation;
						byte_q <= data_byte;
						n_q    <= count;
						done_q <= '0;
						full_q <= 1'b0;
						back_q <= operation == gbe_pkg::OP_BYTE_BACK
							|| operation == gbe_pkg::OP_RUNE_BACK
							|| operation == gbe_pkg::OP_DEL_BYTE_BACK
							|| operation == gbe_pkg::OP_DEL_RUNE_BACK;
						rune_q <= operation == gbe_pkg::OP_RUNE_BACK
							|| operation == gbe_pkg::OP_RUNE_FWD
							|| operation == gbe_pkg::OP_DEL_RUNE_BACK
							|| operation == gbe_pkg::OP_DEL_RUNE_FWD;
						del_q  <= operation == gbe_pkg::OP_DEL_RUNE_BACK
							|| operation == gbe_pkg::OP_DEL_RUNE_FWD;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (op_q)
						gbe_pkg::OP_INSERT: begin
							// The gap must keep one byte after an insert.
							if (gb_q < (AW+1)'(2)) begin
								full_q <= 1'b1;
							end else begin
								gs_q   <= gs_q + AW'(1);
								gb_q   <= gb_q - (AW+1)'(1);
								done_q <= 13'd1;
							end
						end
						gbe_pkg::OP_DEL_BYTE_BACK: begin
							gs_q   <= gs_q - take[AW-1:0];
							gb_q   <= gb_q + take[AW:0];
							done_q <= take[12:0];
						end
						gbe_pkg::OP_DEL_BYTE_FWD: begin
							ge_q   <= ge_q + take[AW-1:0];
							gb_q   <= gb_q + take[AW:0];
							done_q <= take[12:0];
						end
						gbe_pkg::OP_BYTE_BACK, gbe_pkg::OP_BYTE_FWD,
						gbe_pkg::OP_RUNE_BACK, gbe_pkg::OP_RUNE_FWD,
						gbe_pkg::OP_DEL_RUNE_BACK, gbe_pkg::OP_DEL_RUNE_FWD: begin
							state_q <= S_CHK;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_CHK: begin
					// Stop on a reached count or on the end of the text.
					if (done_q >= n_q || lim == 3'd0) begin
						state_q <= S_DONE;
					end else begin
						nread_q <= rune_q ? lim : 3'd1;
						rk_q    <= 2'd0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					rk_q <= rk_q + 2'd1;
					if (3'(rk_q) == nread_q - 3'd1) state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (unit_len == 3'd0) begin
						state_q <= S_DONE;
					end else if (del_q) begin
						if (back_q) gs_q <= gs_q - AW'(unit_len);
						else        ge_q <= ge_q + AW'(unit_len);
						gb_q    <= gb_q + (AW+1)'(unit_len);
						done_q  <= done_q + 13'd1;
						state_q <= S_CHK;
					end else begin
						len_q   <= unit_len;
						wk_q    <= 2'd0;
						state_q <= S_WR;
					end
				end
				S_WR: begin
					wk_q <= wk_q + 2'd1;
					if (3'(wk_q) == len_q - 3'd1) begin
						if (back_q) begin
							gs_q <= gs_q - AW'(len_q);
							ge_q <= ge_q - AW'(len_q);
						end else begin
							gs_q <= gs_q + AW'(len_q);
							ge_q <= ge_q + AW'(len_q);
						end
						done_q  <= done_q + 13'd1;
						state_q <= S_CHK;
					end
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid  <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload; it changes only when a new result is loaded.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid || !out_stall)) begin
			done_count <= done_q;
			cursor_pos <= gs_w[11:0];
			free_bytes <= gb_w[12:0];
			full_res   <= full_q;
		end
	end

	assign in_stall = (state_q != S_IDLE);

`ifndef SYNTH
	a_gap_size: assert property (@(posedge clk) disable iff (!arst_n)
		gb_q == (AW+1)'(ge_q) - (AW+1)'(gs_q) + (AW+1)'(1))
		else $error("gap size out of step with gap pointers");
	a_gap_kept: assert property (@(posedge clk) disable iff (!arst_n)
		gb_q >= (AW+1)'(1))
		else $error("gap vanished");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_EXEC)
		else $error("accepted item not started");
	a_full_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_res |-> done_count == 13'd0)
		else $error("refused insert reports work done");
`endif
endmodule

### sim/testbench.sv
// Self-checking testbench for the UTF-8 gap buffer editor top level.
// It needs gbe_pkg and utf8_gap_buffer_editor_core. It runs a directed table and random edit
// sessions, and checks every result against its own text model or, for typed rows, the row.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Size = 4096;
	localparam int StallLimit = 300000;
	localparam logic [3:0] OP_SPARE_LO = 4'd9;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;

	// One row of the directed table. Where typed is set, the expected result is given in the
	// row itself; otherwise the text model works it out.
	typedef struct packed {
		logic [3:0]  op;
		logic [7:0]  data;
		logic [12:0] cnt;
		logic        typed;
		logic [12:0] e_done;
		logic [11:0] e_cur;
		logic [12:0] e_free;
		logic        e_full;
	} edit_row_t;

	typedef struct packed {
		logic [12:0] done;
		logic [11:0] cur;
		logic [12:0] free;
		logic        full;
	} edit_res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  operation;
	logic [7:0]  data_byte;
	logic [12:0] count;
	logic        out_valid;
	logic        out_stall;
	logic [12:0] done_count;
	logic [11:0] cursor_pos;
	logic [12:0] free_bytes;
	logic        full_res;

	// Typed expectation that travels with the item on the input channel.
	logic        item_typed;
	edit_res_t   item_exp;

	// Text model of the block: the store, the gap and its size.
	logic [7:0]  text_mem [Size];
	int          gap_lo;
	int          gap_hi;
	int          gap_size;

	edit_res_t   pending_q [$];
	int          errors;
	int          idle_cycles;
	int          n_items;
	int          n_results;
	int          n_full;
	bit          calm;

	utf8_gap_buffer_editor_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.data_byte  (data_byte),
		.count      (count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.done_count (done_count),
		.cursor_pos (cursor_pos),
		.free_bytes (free_bytes),
		.full_res   (full_res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Length of a well-formed rune that starts at p with avail readable bytes, else zero.
	// Overlong forms, surrogates and code points above U+10FFFF are all refused.
	function automatic int rune_at(int p, int avail);
		int b0, need, cp, lo;
		if (avail == 0 || p >= Size) return 0;
		b0 = text_mem[p];
		if (b0 < 'h80) return 1;
		if (b0 < 'hC2) return 0;
		if (b0 < 'hE0) begin
			need = 2; cp = b0 & 'h1F; lo = 'h80;
		end else if (b0 < 'hF0) begin
			need = 3; cp = b0 & 'h0F; lo = 'h800;
		end else if (b0 < 'hF5) begin
			need = 4; cp = b0 & 'h07; lo = 'h10000;
		end else begin
			return 0;
		end
		if (need > avail || p + need > Size) return 0;
		for (int k = 1; k < need; k++) begin
			if (text_mem[p + k][7:6] != 2'b10) return 0;
			cp = (cp << 6) | (text_mem[p + k] & 'h3F);
		end
		if (cp < lo || cp > 'h10FFFF || (cp >= 'hD800 && cp <= 'hDFFF)) return 0;
		return need;
	endfunction

	// The rune before the cursor must end on the last byte of the leading text.
	function automatic int rune_left();
		for (int len = 1; len <= 4; len++) begin
			if (len > gap_lo) return 0;
			if (rune_at(gap_lo - len, len) == len) return len;
		end
		return 0;
	endfunction

	function automatic int rune_right();
		if (gap_hi >= Size - 1) return 0;
		return rune_at(gap_hi + 1, Size - 1 - gap_hi);
	endfunction

	// Applies one edit command to the text model and returns the result it should give.
	function automatic edit_res_t apply_edit(logic [3:0] op, logic [7:0] b, logic [12:0] n);
		edit_res_t r;
		int done, len;
		bit full;
		done = 0;
		full = 1'b0;
		case (op)
			gbe_pkg::OP_INSERT: begin
				if (gap_size < 2) begin
					full = 1'b1;
				end else begin
					text_mem[gap_lo] = b;
					gap_lo++; gap_size--; done = 1;
				end
			end
			gbe_pkg::OP_BYTE_BACK:
				while (done < n && gap_lo > 0) begin
					text_mem[gap_hi] = text_mem[gap_lo - 1];
					gap_lo--; gap_hi--; done++;
				end
			gbe_pkg::OP_BYTE_FWD:
				while (done < n && gap_hi < Size - 1) begin
					text_mem[gap_lo] = text_mem[gap_hi + 1];
					gap_lo++; gap_hi++; done++;
				end
			gbe_pkg::OP_RUNE_BACK:
				while (done < n && (len = rune_left()) != 0) begin
					// Copy from the top byte down so that an overlap cannot corrupt the rune.
					for (int k = len - 1; k >= 0; k--)
						text_mem[gap_hi + 1 - len + k] = text_mem[gap_lo - len + k];
					gap_lo -= len; gap_hi -= len; done++;
				end
			gbe_pkg::OP_RUNE_FWD:
				while (done < n && (len = rune_right()) != 0) begin
					for (int k = 0; k < len; k++)
						text_mem[gap_lo + k] = text_mem[gap_hi + 1 + k];
					gap_lo += len; gap_hi += len; done++;
				end
			gbe_pkg::OP_DEL_BYTE_BACK:
				while (done < n && gap_lo > 0) begin
					gap_lo--; gap_size++; done++;
				end
			gbe_pkg::OP_DEL_BYTE_FWD:
				while (done < n && gap_hi < Size - 1) begin
					gap_hi++; gap_size++; done++;
				end
			gbe_pkg::OP_DEL_RUNE_BACK:
				while (done < n && (len = rune_left()) != 0) begin
					gap_lo -= len; gap_size += len; done++;
				end
			gbe_pkg::OP_DEL_RUNE_FWD:
				while (done < n && (len = rune_right()) != 0) begin
					gap_hi += len; gap_size += len; done++;
				end
			default: ;
		endcase
		r.done = done[12:0];
		r.cur  = gap_lo[11:0];
		r.free = gap_size[12:0];
		r.full = full;
		return r;
	endfunction

	// Both channels are watched at the rising edge, before any of this edge's updates land.
	always @(posedge clk) begin
		edit_res_t want, got;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				want = apply_edit(operation, data_byte, count);
				if (item_typed) want = item_exp;
				if (operation == gbe_pkg::OP_INSERT && want.full) n_full++;
				pending_q.push_back(want);
				n_items++;
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				n_results++;
				got = '{done_count, cursor_pos, free_bytes, full_res};
				if (pending_q.size() == 0) begin
					$display("%0t: result with nothing expected: done %0d cursor %0d free %0d full %0b",
						$time, got.done, got.cur, got.free, got.full);
					errors++;
				end else begin
					want = pending_q.pop_front();
					if (got.done !== want.done) begin
						$display("%0t: done_count expected %0d actual %0d", $time, want.done, got.done);
						errors++;
					end
					if (got.cur !== want.cur) begin
						$display("%0t: cursor_pos expected %0d actual %0d", $time, want.cur, got.cur);
						errors++;
					end
					if (got.free !== want.free) begin
						$display("%0t: free_bytes expected %0d actual %0d", $time, want.free, got.free);
						errors++;
					end
					if (got.full !== want.full) begin
						$display("%0t: full_res expected %0b actual %0b", $time, want.full, got.full);
						errors++;
					end
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
			out_stall <= !calm && ($urandom_range(99) < 26);
		end
	end

	// Hands one item to the block and returns at the edge that accepts it.
	task automatic put_item(logic [3:0] op, logic [7:0] b, logic [12:0] n, logic typed,
		edit_res_t exp_res);
		if (!calm && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		data_byte  <= b;
		count      <= n;
		item_typed <= typed;
		item_exp   <= exp_res;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// The last item is logged at its accepting edge, so drain waits for a clock edge before the check.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	// Inserts one well-formed rune of random length and content, byte by byte.
	task automatic put_rune();
		int cp, nb;
		logic [7:0] enc [4];
		case ($urandom_range(3))
			0: cp = $urandom_range('h7F);
			1: cp = $urandom_range('h80, 'h7FF);
			2: begin
				cp = $urandom_range('h800, 'hFFFF);
				if (cp >= 'hD800 && cp <= 'hDFFF) cp = 'hFFFD;
			end
			default: cp = $urandom_range('h10000, 'h10FFFF);
		endcase
		if (cp < 'h80) begin
			nb = 1; enc[0] = 8'(cp);
		end else if (cp < 'h800) begin
			nb = 2; enc[0] = 8'('hC0 | (cp >> 6));
		end else if (cp < 'h10000) begin
			nb = 3; enc[0] = 8'('hE0 | (cp >> 12));
		end else begin
			nb = 4; enc[0] = 8'('hF0 | (cp >> 18));
		end
		for (int k = 1; k < nb; k++)
			enc[k] = 8'('h80 | ((cp >> (6 * (nb - 1 - k))) & 'h3F));
		for (int k = 0; k < nb; k++) put_item(gbe_pkg::OP_INSERT, enc[k], '0, 1'b0, '0);
	endtask

	// Directed rows: an empty buffer first, then one rune of each length, a validly
	// encoded replacement character, a stray continuation byte and an encoded surrogate,
	// followed by moves and deletes that run into those and into the ends of the text.
	edit_row_t dir_tab [] = '{
		'{gbe_pkg::OP_BYTE_BACK,     8'h00, 13'd5,    1'b1, 13'd0, 12'd0, 13'd4096, 1'b0},
		'{gbe_pkg::OP_DEL_RUNE_FWD,  8'h00, 13'd4096, 1'b1, 13'd0, 12'd0, 13'd4096, 1'b0},
		'{OP_SPARE_HI,               8'hFF, 13'd8191, 1'b1, 13'd0, 12'd0, 13'd4096, 1'b0},
		'{gbe_pkg::OP_INSERT,        8'h41, 13'd0,    1'b1, 13'd1, 12'd1, 13'd4095, 1'b0},
		'{gbe_pkg::OP_INSERT,        8'hC3, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'hA9, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'hE2, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'h82, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'hAC, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'hF0, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'h9F, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'h98, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'h80, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'hEF, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'hBF, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'hBD, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_RUNE_BACK,     8'h00, 13'd4096, 1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_RUNE_FWD,      8'h00, 13'd4096, 1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'h80, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'hED, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'hA0, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_INSERT,        8'h80, 13'd0,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_RUNE_BACK,     8'h00, 13'd4096, 1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_BYTE_BACK,     8'h00, 13'd9,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_DEL_RUNE_BACK, 8'h00, 13'd2,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_DEL_BYTE_FWD,  8'h00, 13'd1,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_BYTE_FWD,      8'h00, 13'd4096, 1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{gbe_pkg::OP_DEL_BYTE_BACK, 8'h00, 13'd3,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0},
		'{OP_SPARE_LO,               8'h00, 13'd1,    1'b0, 13'd0, 12'd0, 13'd0,    1'b0}
	};

	// Watchdog: too long without any item moving on either channel ends the run.
	initial begin
		wait (idle_cycles >= StallLimit);
		$display("%0t: no progress for %0d cycles", $time, StallLimit);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		edit_res_t none;
		logic [3:0] op;
		logic [12:0] n;
		none        = '0;
		errors      = 0;
		idle_cycles = 0;
		n_items     = 0;
		n_results   = 0;
		n_full      = 0;
		calm        = 1'b0;
		gap_lo      = 0;
		gap_hi      = Size - 1;
		gap_size    = Size;
		for (int i = 0; i < Size; i++) text_mem[i] = '0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		operation  = gbe_pkg::OP_INSERT;
		data_byte  = '0;
		count      = '0;
		out_stall  = 1'b0;
		item_typed = 1'b0;
		item_exp   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			put_item(dir_tab[i].op, dir_tab[i].data, dir_tab[i].cnt, dir_tab[i].typed,
				'{dir_tab[i].e_done, dir_tab[i].e_cur, dir_tab[i].e_free, dir_tab[i].e_full});

		// Let everything settle once before the random sessions start.
		drain();

		// Random edit sessions: mostly well-formed runes with cursor work in between, some
		// raw bytes as noise. A stretch in the middle runs with no idling on either side.
		for (int i = 0; i < 260; i++) begin
			calm = (i >= 100 && i < 160);
			case ($urandom_range(9))
				0, 1, 2, 3: put_rune();
				4: put_item(gbe_pkg::OP_INSERT, 8'($urandom_range(255)),
					13'($urandom_range(8191)), 1'b0, none);
				default: begin
					op = $urandom_range(99) < 8 ? 4'($urandom_range(9, 15))
						: 4'($urandom_range(1, 8));
					case ($urandom_range(19))
						0: n = 13'd4096;
						1: n = 13'd0;
						2: n = 13'($urandom_range(40));
						default: n = 13'($urandom_range(1, 6));
					endcase
					put_item(op, 8'($urandom_range(255)), n, 1'b0, none);
				end
			endcase
		end

		// Run into both ends of the text once more, then insert into the emptied buffer.
		drain();
		calm = 1'b0;
		put_item(gbe_pkg::OP_INSERT, 8'h5A, 13'd4096, 1'b0, none);
		put_item(gbe_pkg::OP_RUNE_BACK, 8'h00, 13'd3, 1'b0, none);
		put_item(gbe_pkg::OP_DEL_BYTE_BACK, 8'h00, 13'd4096, 1'b0, none);
		put_item(gbe_pkg::OP_DEL_BYTE_FWD, 8'h00, 13'd4096, 1'b0, none);
		put_item(gbe_pkg::OP_INSERT, 8'h7E, 13'd0, 1'b0, none);

		drain();
		repeat (40) @(posedge clk);
		$display("Edit commands accepted: %0d, results checked: %0d, refused inserts: %0d.",
			n_items, n_results, n_full);
		$display("Covered rune and byte moves and deletes, invalid UTF-8, spare codes and text ends.");
		if (errors == 0 && pending_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
